[hw/rtl/pad_pkg.sv]
// shared types and constants for the polygon area / degenerate check unit
// no dependencies
`default_nettype none

package pad_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int COORD_BITS   = 16;
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 2);
    localparam int PROD_BITS    = 2 * COORD_BITS;
    localparam int DIFF_BITS    = 2 * COORD_BITS + 1;
    localparam int SUM_BITS     = 2 * COORD_BITS + 13;
    localparam int AREA_BITS    = 44;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [CNT_BITS-1:0] CNT_MAX   = CNT_BITS'(MAX_VERTICES);
    localparam logic [CNT_BITS-1:0] CNT_OVER  = CNT_BITS'(MAX_VERTICES + 1);
    localparam logic [CNT_BITS-1:0] CNT_FEW   = CNT_BITS'(3);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // edge term: e_px*e_cy - e_cx*e_py, closing term: c_ax*c_fy - c_fx*c_ay
    typedef struct packed {
        coord_t e_px;
        coord_t e_py;
        coord_t e_cx;
        coord_t e_cy;
        coord_t c_ax;
        coord_t c_ay;
        coord_t c_fx;
        coord_t c_fy;
        logic   last;
        logic   few;
        logic   over;
    } pad_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pad_fifo_status_t;

endpackage

`default_nettype wire

[hw/rtl/pad_front.sv]
// front end: accepts vertex beats, tracks first/previous vertex and count
// builds one queue entry per beat; depends on pad_pkg
`default_nettype none

module pad_front
    import pad_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire coord_t     vertex_x,
    input  wire coord_t     vertex_y,
    input  wire logic       last_vertex,
    output pad_entry_t      entry
);

    coord_t              first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    coord_t              first_x_next, first_y_next, prev_x_next, prev_y_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                is_first, is_edge;

    always_comb
    begin
        is_first = (count_reg == '0);
        is_edge  = !is_first && (count_reg < CNT_MAX);

        if (is_first)
            count_next = CNT_BITS'(1);
        else if (is_edge)
            count_next = count_reg + CNT_BITS'(1);
        else
            count_next = CNT_OVER;

        first_x_next = is_first ? vertex_x : first_x_reg;
        first_y_next = is_first ? vertex_y : first_y_reg;
        prev_x_next  = (is_first || is_edge) ? vertex_x : prev_x_reg;
        prev_y_next  = (is_first || is_edge) ? vertex_y : prev_y_reg;

        entry.e_px = is_edge ? prev_x_reg : '0;
        entry.e_py = is_edge ? prev_y_reg : '0;
        entry.e_cx = is_edge ? vertex_x   : '0;
        entry.e_cy = is_edge ? vertex_y   : '0;
        entry.c_ax = last_vertex ? prev_x_next  : '0;
        entry.c_ay = last_vertex ? prev_y_next  : '0;
        entry.c_fx = last_vertex ? first_x_next : '0;
        entry.c_fy = last_vertex ? first_y_next : '0;
        entry.last = last_vertex;
        entry.few  = (count_next < CNT_FEW);
        entry.over = (count_next > CNT_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_vertex)
            begin
                count_reg   <= '0;
                first_x_reg <= '0;
                first_y_reg <= '0;
                prev_x_reg  <= '0;
                prev_y_reg  <= '0;
            end
            else
            begin
                count_reg   <= count_next;
                first_x_reg <= first_x_next;
                first_y_reg <= first_y_next;
                prev_x_reg  <= prev_x_next;
                prev_y_reg  <= prev_y_next;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/pad_fifo.sv]
// short queue between front and back ends
// depends on pad_pkg
`default_nettype none

module pad_fifo
    import pad_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire pad_entry_t push_entry,
    input  wire logic       pop,
    output pad_entry_t      head,
    output pad_fifo_status_t status
);

    pad_entry_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;

    assign status.full  = (count_reg == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + FIFO_CNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - FIFO_CNT_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_BITS'(1);
            count_reg <= count_next;
        end
    end

    no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue written while full");

    no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");

    count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

[hw/rtl/pad_back.sv]
// back end: cross products, shoelace accumulation, magnitude and threshold
// depends on pad_pkg
`default_nettype none

module pad_back
    import pad_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pad_entry_t           head,
    input  wire pad_fifo_status_t     status,
    output logic                      pop,
    input  wire logic [AREA_BITS-1:0] min_area_halves,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [AREA_BITS-1:0]      area_halves,
    output logic                      degenerate,
    output logic                      too_many_vertices
);

    logic adv;

    logic                        s1_valid_reg;
    logic signed [PROD_BITS-1:0] s1_p1_reg, s1_p2_reg, s1_p3_reg, s1_p4_reg;
    logic                        s1_last_reg, s1_few_reg, s1_over_reg;

    logic                        s2_valid_reg;
    logic signed [DIFF_BITS-1:0] s2_e1_reg, s2_e2_reg;
    logic                        s2_last_reg, s2_few_reg, s2_over_reg;

    logic [SUM_BITS-1:0]         acc_reg, acc_next;
    logic                        s3_valid_reg;
    logic [SUM_BITS-1:0]         s3_sum_reg;
    logic                        s3_few_reg, s3_over_reg;

    logic [SUM_BITS-1:0]         mag;
    logic [AREA_BITS-1:0]        area_next;
    logic                        s4_valid_reg;
    logic [AREA_BITS-1:0]        s4_area_reg;
    logic                        s4_few_reg, s4_over_reg;

    logic                        out_valid_reg;
    logic [AREA_BITS-1:0]        out_area_reg;
    logic                        out_degen_reg, out_over_reg;

    assign adv = !(out_valid_reg && result_stall);
    assign pop = adv && !status.empty;

    always_comb
    begin
        acc_next = acc_reg + SUM_BITS'(s2_e1_reg) + SUM_BITS'(s2_e2_reg);
        mag = s3_sum_reg[SUM_BITS-1] ? (SUM_BITS'(0) - s3_sum_reg) : s3_sum_reg;
        if (s3_few_reg)
            area_next = '0;
        else if (|mag[SUM_BITS-1:AREA_BITS])
            area_next = '1;
        else
            area_next = mag[AREA_BITS-1:0];
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_p1_reg   <= PROD_BITS'(head.e_px) * PROD_BITS'(head.e_cy);
            s1_p2_reg   <= PROD_BITS'(head.e_cx) * PROD_BITS'(head.e_py);
            s1_p3_reg   <= PROD_BITS'(head.c_ax) * PROD_BITS'(head.c_fy);
            s1_p4_reg   <= PROD_BITS'(head.c_fx) * PROD_BITS'(head.c_ay);
            s1_last_reg <= head.last;
            s1_few_reg  <= head.few;
            s1_over_reg <= head.over;

            s2_e1_reg   <= DIFF_BITS'(s1_p1_reg) - DIFF_BITS'(s1_p2_reg);
            s2_e2_reg   <= DIFF_BITS'(s1_p3_reg) - DIFF_BITS'(s1_p4_reg);
            s2_last_reg <= s1_last_reg;
            s2_few_reg  <= s1_few_reg;
            s2_over_reg <= s1_over_reg;

            s3_sum_reg  <= acc_next;
            s3_few_reg  <= s2_few_reg;
            s3_over_reg <= s2_over_reg;

            s4_area_reg <= area_next;
            s4_few_reg  <= s3_few_reg;
            s4_over_reg <= s3_over_reg;

            out_area_reg  <= s4_area_reg;
            out_degen_reg <= s4_few_reg || (s4_area_reg < min_area_halves);
            out_over_reg  <= s4_over_reg;
        end
    end

    // control and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg && s2_last_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
            if (s2_valid_reg)
                acc_reg <= s2_last_reg ? '0 : acc_next;
        end
    end

    assign result_valid      = out_valid_reg;
    assign area_halves       = out_area_reg;
    assign degenerate        = out_degen_reg;
    assign too_many_vertices = out_over_reg;

endmodule

`default_nettype wire

[hw/rtl/polygon_area_degenerate_check_unit.sv]
// path: a beat marked last goes from the queue through s1, s2, s3, s4 and the output register
// throughput: one vertex beat per cycle while no result waits on result_stall, set by the four
//   16x16 multipliers working side by side in the first back-end stage; the 4-entry queue
//   keeps taking beats while a result waits on result_stall, until it is full
// reset: queue and pipeline empty, polygon state cleared, threshold 0
// top level; depends on pad_pkg, pad_front, pad_fifo, pad_back
`default_nettype none

module polygon_area_degenerate_check_unit
    import pad_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [AREA_BITS-1:0] cfg_wr_data,
    input  wire logic                 vertex_valid,
    output logic                      vertex_stall,
    input  wire coord_t               vertex_x,
    input  wire coord_t               vertex_y,
    input  wire logic                 last_vertex,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [AREA_BITS-1:0]      area_halves,
    output logic                      degenerate,
    output logic                      too_many_vertices
);

    logic [AREA_BITS-1:0] min_area_halves_reg;
    logic                 accept;
    logic                 pop;
    pad_entry_t           front_entry;
    pad_entry_t           head;
    pad_fifo_status_t     status;

    assign vertex_stall = status.full;
    assign accept       = vertex_valid && !status.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_area_halves_reg <= '0;
        else if (cfg_wr_en)
            min_area_halves_reg <= cfg_wr_data;
    end

    pad_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .last_vertex (last_vertex),
        .entry       (front_entry)
    );

    pad_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (front_entry),
        .pop        (pop),
        .head       (head),
        .status     (status)
    );

    pad_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .status            (status),
        .pop               (pop),
        .min_area_halves   (min_area_halves_reg),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .area_halves       (area_halves),
        .degenerate        (degenerate),
        .too_many_vertices (too_many_vertices)
    );

endmodule

`default_nettype wire

[tb/polygon_area_checker.sv]
// checker for the polygon area / degenerate check unit: watches the config port and
// both beat channels, predicts each polygon result and compares it field by field
// depends on pad_pkg
`timescale 1ns / 100ps

module polygon_area_checker
    import pad_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [AREA_BITS-1:0] cfg_wr_data,
    input  wire logic                 vertex_valid,
    input  wire logic                 vertex_stall,
    input  wire coord_t               vertex_x,
    input  wire coord_t               vertex_y,
    input  wire logic                 last_vertex,
    input  wire logic                 result_valid,
    input  wire logic                 result_stall,
    input  wire logic [AREA_BITS-1:0] area_halves,
    input  wire logic                 degenerate,
    input  wire logic                 too_many_vertices,
    output int                        mismatches,
    output int                        outstanding
);

    typedef struct packed {
        logic [AREA_BITS-1:0] area;
        logic                 degenerate;
        logic                 over;
    } polygon_result_t;

    polygon_result_t      polygon_results_q[$];
    logic [AREA_BITS-1:0] min_area;
    coord_t               first_x;
    coord_t               first_y;
    coord_t               prev_x;
    coord_t               prev_y;
    logic [SUM_BITS-1:0]  cross_sum;
    int                   vertex_count;
    int                   fail_total;

    function automatic logic [SUM_BITS-1:0] edge_cross(coord_t ax, coord_t ay,
                                                      coord_t bx, coord_t by);
        longint prod;
        prod = longint'(ax) * longint'(by) - longint'(bx) * longint'(ay);
        return prod[SUM_BITS-1:0];
    endfunction

    task automatic clear_polygon();
        first_x      = '0;
        first_y      = '0;
        prev_x       = '0;
        prev_y       = '0;
        cross_sum    = '0;
        vertex_count = 0;
    endtask

    task automatic shoelace_vertex(coord_t x, coord_t y, logic last);
        logic [SUM_BITS-1:0] mag;
        polygon_result_t     res;
        logic                few;
        if (vertex_count == 0)
        begin
            first_x      = x;
            first_y      = y;
            prev_x       = x;
            prev_y       = y;
            vertex_count = 1;
        end
        else if (vertex_count < MAX_VERTICES)
        begin
            cross_sum    = cross_sum + edge_cross(prev_x, prev_y, x, y);
            prev_x       = x;
            prev_y       = y;
            vertex_count = vertex_count + 1;
        end
        else
        begin
            vertex_count = MAX_VERTICES + 1;
        end
        if (last)
        begin
            // closing edge back to the first vertex
            cross_sum = cross_sum + edge_cross(prev_x, prev_y, first_x, first_y);
            mag = cross_sum[SUM_BITS-1] ? -cross_sum : cross_sum;
            few = vertex_count < 3;
            if (few)
                res.area = '0;
            else if (mag > {AREA_BITS{1'b1}})
                res.area = '1;
            else
                res.area = mag[AREA_BITS-1:0];
            res.degenerate = few || (res.area < min_area);
            res.over       = vertex_count > MAX_VERTICES;
            polygon_results_q.push_back(res);
            clear_polygon();
        end
    endtask

    task automatic compare_result();
        polygon_result_t exp_r;
        if (polygon_results_q.size() == 0)
        begin
            $error("unexpected result beat: area_halves %0d", area_halves);
            fail_total++;
        end
        else
        begin
            exp_r = polygon_results_q.pop_front();
            if (area_halves !== exp_r.area)
            begin
                $error("area_halves expected %0d actual %0d", exp_r.area, area_halves);
                fail_total++;
            end
            if (degenerate !== exp_r.degenerate)
            begin
                $error("degenerate expected %0d actual %0d", exp_r.degenerate, degenerate);
                fail_total++;
            end
            if (too_many_vertices !== exp_r.over)
            begin
                $error("too_many_vertices expected %0d actual %0d", exp_r.over,
                       too_many_vertices);
                fail_total++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_polygon();
            polygon_results_q.delete();
            min_area    = '0;
            fail_total  = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                compare_result();
            if (vertex_valid && !vertex_stall)
                shoelace_vertex(vertex_x, vertex_y, last_vertex);
            if (cfg_wr_en)
                min_area = cfg_wr_data;
            mismatches  <= fail_total;
            outstanding <= polygon_results_q.size();
        end
    end

endmodule

[tb/polygon_area_degenerate_check_unit_test.sv]
// top of the testbench for polygon_area_degenerate_check_unit: drives vertex beats,
// threshold writes and result stalls, and gives the verdict
// depends on pad_pkg, polygon_area_checker and the unit itself
`timescale 1ns / 100ps

module polygon_area_degenerate_check_unit_test;
    import pad_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [AREA_BITS-1:0] cfg_wr_data;
    logic                 vertex_valid;
    logic                 vertex_stall;
    coord_t               vertex_x;
    coord_t               vertex_y;
    logic                 last_vertex;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [AREA_BITS-1:0] area_halves;
    logic                 degenerate;
    logic                 too_many_vertices;
    int                   mismatches;
    int                   outstanding;
    int                   cycle_count = 0;
    int                   send_idle_pct = 0;
    int                   stall_pct = 0;
    int                   vertices_sent = 0;

    polygon_area_degenerate_check_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .vertex_valid      (vertex_valid),
        .vertex_stall      (vertex_stall),
        .vertex_x          (vertex_x),
        .vertex_y          (vertex_y),
        .last_vertex       (last_vertex),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .area_halves       (area_halves),
        .degenerate        (degenerate),
        .too_many_vertices (too_many_vertices)
    );

    polygon_area_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .vertex_valid      (vertex_valid),
        .vertex_stall      (vertex_stall),
        .vertex_x          (vertex_x),
        .vertex_y          (vertex_y),
        .last_vertex       (last_vertex),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .area_halves       (area_halves),
        .degenerate        (degenerate),
        .too_many_vertices (too_many_vertices),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic coord_t pick_coord(int style);
        int roll;
        roll = $urandom_range(9);
        if (roll == 0 || style == 2)
        begin
            case ($urandom_range(3))
                0: return coord_t'(-32768);
                1: return coord_t'(32767);
                2: return coord_t'(0);
                default: return coord_t'(-1);
            endcase
        end
        else if (style == 0)
            return coord_t'($urandom_range(128) - 64);
        else
            return coord_t'($urandom);
    endfunction

    task automatic send_vertex(coord_t x, coord_t y, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            vertex_valid <= 1'b0;
            @(posedge clk);
        end
        vertex_valid <= 1'b1;
        vertex_x     <= x;
        vertex_y     <= y;
        last_vertex  <= last;
        @(posedge clk);
        while (vertex_stall)
            @(posedge clk);
        vertices_sent++;
    endtask

    task automatic send_xy(int x, int y, logic last);
        send_vertex(coord_t'(x), coord_t'(y), last);
    endtask

    task automatic send_polygon(int count, int style);
        for (int i = 0; i < count; i++)
            send_vertex(pick_coord(style), pick_coord(style), i == count - 1);
    endtask

    task automatic random_polygons(int goal);
        int start;
        int count;
        int roll;
        start = vertices_sent;
        while (vertices_sent - start < goal)
        begin
            count = ($urandom_range(99) < 8) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            roll  = $urandom_range(9);
            send_polygon(count, (roll < 4) ? 0 : (roll < 8) ? 1 : 2);
        end
    endtask

    task automatic wait_idle();
        vertex_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_min_area(logic [AREA_BITS-1:0] value);
        wait_idle();
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic directed_polygons();
        // single vertex, then two vertices
        send_xy(5, -7, 1'b1);
        send_xy(1, 2, 1'b0);
        send_xy(3, 4, 1'b1);
        // just under and exactly at the threshold of 100
        send_xy(0, 0, 1'b0);
        send_xy(11, 0, 1'b0);
        send_xy(0, 9, 1'b1);
        send_xy(0, 0, 1'b0);
        send_xy(10, 0, 1'b0);
        send_xy(10, 5, 1'b0);
        send_xy(0, 5, 1'b1);
        // clockwise, negative sum
        send_xy(0, 0, 1'b0);
        send_xy(0, 5, 1'b0);
        send_xy(10, 5, 1'b0);
        send_xy(10, 0, 1'b1);
        // full coordinate range square
        send_xy(-32768, -32768, 1'b0);
        send_xy(32767, -32768, 1'b0);
        send_xy(32767, 32767, 1'b0);
        send_xy(-32768, 32767, 1'b1);
        // collinear, zero area; then a large triangle
        send_xy(-32768, -32768, 1'b0);
        send_xy(-1, -1, 1'b0);
        send_xy(32767, 32767, 1'b1);
        send_xy(-1, 32767, 1'b0);
        send_xy(32767, -32768, 1'b0);
        send_xy(-32768, 0, 1'b1);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        vertex_valid <= 1'b0;
        vertex_x     <= '0;
        vertex_y     <= '0;
        last_vertex  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_min_area(44'd100);
        directed_polygons();

        write_min_area(AREA_BITS'($urandom_range(1000, 8000)));
        send_idle_pct = 38;
        stall_pct     = 80;
        random_polygons(510);

        write_min_area(44'h001_0000_0000);
        send_idle_pct = 80;
        stall_pct     = 38;
        random_polygons(510);

        write_min_area('1);
        send_idle_pct = 0;
        stall_pct     = 0;
        random_polygons(510);

        write_min_area('0);
        random_polygons(200);

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
